// ===== rtl/pool2d_pkg.sv =====
package pool2d_pkg;

	// default sizes of the plane store and datapath
	localparam int MAX_DIM_DEF = 64;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int MAX_KERNEL_DEF = 8;

	// configuration port and register widths
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 7;
	localparam int KSZ_W = 4;
	localparam int STRIDE_W = 4;
	localparam int PAD_W = 3;
	localparam int DIM_CFG_W = 7;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE_STEP = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAD_AMOUNT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POOL_MODE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_HEIGHT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_WIDTH = 3'd5;

	// register reset values
	localparam logic [KSZ_W-1:0] KSZ_RESET = 4'd2;
	localparam logic [DIM_CFG_W-1:0] DIM_RESET = 7'd64;

	// kernel size used when the register holds zero
	localparam int K_ZERO_SUB = 2;

	// command and mode codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_COMPUTE = 1'b1;
	localparam logic MODE_MAX = 1'b0;
	localparam logic MODE_AVG = 1'b1;

	// result status codes
	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_SETUP,
		FSM_CHECK,
		FSM_SCAN,
		FSM_DRAIN,
		FSM_DIV_LOAD,
		FSM_DIVIDE,
		FSM_FINISH
	} fsm_state_t;

endpackage

// ===== rtl/pool2d_max_avg_window_unit.sv =====
// 2-d max / average pooling over one plane of signed fixed-point samples.
// input channel (in_valid/in_ready): cmd 0 loads sample_in at (row_pos, col_pos)
// into the plane store, cmd 1 computes the output at output position (row_pos, col_pos).
// output channel (out_valid/out_ready): one transaction per compute, none per load.
// config channel (cfg_valid/cfg_ready): cfg_index selects kernel_size, stride_step,
// pad_amount, pool_mode, plane_height, plane_width; always ready, write only while idle.
// a load is written straight into the plane store. a compute walks the K*K window one store read
// per cycle through the single read port of the plane store, then registers the result
// in max mode. average mode adds a bit-serial divide by K*K when the window held samples.
// an out-of-range position skips the walk and returns a range status.
// one item is in work at a time; in_ready is high whenever the sequencer is idle,
// also while a finished result still sits in the output register.
// when the receiver stalls, the result holds in the output register and the next
// compute waits at its end for that register to free up.
// reset returns the config registers to K=2, stride=K, no padding, max mode, 64x64
// and empties the output register. the plane store is not cleared: each entry must
// be loaded before a window reads it.
module pool2d_max_avg_window_unit
	import pool2d_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int MAX_KERNEL = MAX_KERNEL_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic cmd,
	input logic [$clog2(MAX_DIM)-1:0] row_pos,
	input logic [$clog2(MAX_DIM)-1:0] col_pos,
	input logic signed [SAMPLE_BITS-1:0] sample_in,
	output logic out_valid,
	input logic out_ready,
	output logic signed [SAMPLE_BITS-1:0] pooled_value,
	output logic [2*$clog2(MAX_DIM)-1:0] max_index,
	output logic [1:0] status_code,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int POS_W = $clog2(MAX_DIM);
	localparam int IDX_W = 2 * POS_W;
	localparam int DEPTH = 1 << IDX_W;
	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int KW = $clog2(MAX_KERNEL + 1);
	localparam int S_W = (KW > KSZ_W) ? KW : KSZ_W;
	localparam int PR_W = POS_W + S_W;
	localparam int CW = POS_W + S_W + 3;
	localparam int KK_W = 2 * KW;
	localparam int RW = KK_W + 1;
	localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_KERNEL * MAX_KERNEL + 1);
	localparam int DC_W = $clog2(SUM_W + 1);

	// configuration registers
	logic [KSZ_W-1:0] kernel_q;
	logic [STRIDE_W-1:0] stride_q;
	logic [PAD_W-1:0] pad_q;
	logic mode_q;
	logic [DIM_CFG_W-1:0] height_q;
	logic [DIM_CFG_W-1:0] width_q;

	fsm_state_t state_q, state_d;

	logic in_acc;
	logic mem_we;
	logic issue_en;
	logic clr_acc;
	logic out_load;

	logic [KSZ_W-1:0] k_raw;
	logic [KW-1:0] k_eff;
	logic [KW-1:0] k_last;
	logic [S_W-1:0] s_eff;
	logic [DIM_W-1:0] h_eff;
	logic [DIM_W-1:0] w_eff;
	logic [KK_W-1:0] kk;

	logic [POS_W-1:0] pos_r_q, pos_c_q;
	logic [PR_W-1:0] prod_r_q, prod_c_q;
	logic signed [CW-1:0] base_r_q, base_c_q;
	logic signed [CW-1:0] span_h, span_w;
	logic rng;
	logic range_q;

	logic [KW-1:0] kh_q, kw_q;
	logic scan_last;
	logic signed [CW-1:0] ih, iw;
	logic inb;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] idx_calc;

	logic [SAMPLE_BITS-1:0] mem [DEPTH];
	logic signed [SAMPLE_BITS-1:0] rd_data_s1;
	logic vld_s1;
	logic [IDX_W-1:0] idx_s1;

	logic signed [SUM_W-1:0] sum_q;
	logic signed [SAMPLE_BITS-1:0] best_q;
	logic [IDX_W-1:0] best_idx_q;
	logic seen_q;

	logic [SUM_W-1:0] dvd_q;
	logic [RW-1:0] rem_q;
	logic [RW-1:0] rem_sh;
	logic div_ge;
	logic [KK_W-1:0] kk_q;
	logic neg_q;
	logic [DC_W-1:0] div_cnt_q;
	logic [SUM_W-1:0] avg_full;

	logic signed [SAMPLE_BITS-1:0] res_value;
	logic [IDX_W-1:0] res_idx;
	logic [1:0] res_status;

	logic out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_value_q;
	logic [IDX_W-1:0] out_idx_q;
	logic [1:0] out_status_q;

	assign cfg_ready = 1'b1;
	assign in_acc = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_q <= KSZ_RESET;
			stride_q <= '0;
			pad_q <= '0;
			mode_q <= MODE_MAX;
			height_q <= DIM_RESET;
			width_q <= DIM_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_KERNEL_SIZE: kernel_q <= cfg_data[KSZ_W-1:0];
				REG_STRIDE_STEP: stride_q <= cfg_data[STRIDE_W-1:0];
				REG_PAD_AMOUNT: pad_q <= cfg_data[PAD_W-1:0];
				REG_POOL_MODE: mode_q <= cfg_data[0];
				REG_PLANE_HEIGHT: height_q <= cfg_data[DIM_CFG_W-1:0];
				REG_PLANE_WIDTH: width_q <= cfg_data[DIM_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// effective window geometry
	assign k_raw = (kernel_q == '0) ? KSZ_W'(K_ZERO_SUB) : kernel_q;
	assign k_eff = (int'(k_raw) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(k_raw);
	assign k_last = k_eff - KW'(1);
	assign s_eff = (stride_q == '0) ? S_W'(k_eff) : S_W'(stride_q);
	assign h_eff = (height_q == '0) ? DIM_W'(1) :
		(int'(height_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(height_q);
	assign w_eff = (width_q == '0) ? DIM_W'(1) :
		(int'(width_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(width_q);
	assign kk = KK_W'(k_eff) * KK_W'(k_eff);

	// position in range iff pos*S <= dim + 2P - K
	assign span_h = CW'(h_eff) + CW'({pad_q, 1'b0}) - CW'(k_eff);
	assign span_w = CW'(w_eff) + CW'({pad_q, 1'b0}) - CW'(k_eff);
	assign rng = span_h[CW-1] || span_w[CW-1] ||
		($signed(CW'(prod_r_q)) > span_h) || ($signed(CW'(prod_c_q)) > span_w);

	// window walk, one store read per cycle
	assign ih = base_r_q + $signed(CW'(kh_q));
	assign iw = base_c_q + $signed(CW'(kw_q));
	assign inb = !ih[CW-1] && (ih < $signed(CW'(h_eff))) &&
		!iw[CW-1] && (iw < $signed(CW'(w_eff)));
	assign rd_addr = {ih[POS_W-1:0], iw[POS_W-1:0]};
	assign idx_calc = IDX_W'(ih[POS_W-1:0]) * IDX_W'(w_eff) + IDX_W'(iw[POS_W-1:0]);
	assign scan_last = (kh_q == k_last) && (kw_q == k_last);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (in_valid && cmd == CMD_COMPUTE) state_d = FSM_SETUP;
			end
			FSM_SETUP: state_d = FSM_CHECK;
			FSM_CHECK: state_d = rng ? FSM_FINISH : FSM_SCAN;
			FSM_SCAN: begin
				if (scan_last) state_d = FSM_DRAIN;
			end
			FSM_DRAIN: begin
				if (mode_q == MODE_AVG && (seen_q || vld_s1)) state_d = FSM_DIV_LOAD;
				else state_d = FSM_FINISH;
			end
			FSM_DIV_LOAD: state_d = FSM_DIVIDE;
			FSM_DIVIDE: begin
				if (div_cnt_q == '0) state_d = FSM_FINISH;
			end
			FSM_FINISH: begin
				if (!out_valid_q || out_ready) state_d = FSM_IDLE;
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == FSM_IDLE);
		issue_en = (state_q == FSM_SCAN);
		clr_acc = (state_q == FSM_CHECK);
		out_load = (state_q == FSM_FINISH) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= FSM_IDLE;
		else state_q <= state_d;
	end

	// plane store: one write port, one registered read port
	assign mem_we = in_acc && (cmd == CMD_LOAD) &&
		(int'(row_pos) < MAX_DIM) && (int'(col_pos) < MAX_DIM);

	always_ff @(posedge clk) begin
		if (mem_we) mem[{row_pos, col_pos}] <= sample_in;
		rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pos_r_q <= row_pos;
			pos_c_q <= col_pos;
		end
		if (state_q == FSM_SETUP) begin
			prod_r_q <= PR_W'(pos_r_q) * PR_W'(s_eff);
			prod_c_q <= PR_W'(pos_c_q) * PR_W'(s_eff);
		end
		if (clr_acc) begin
			base_r_q <= $signed(CW'(prod_r_q)) - $signed(CW'(pad_q));
			base_c_q <= $signed(CW'(prod_c_q)) - $signed(CW'(pad_q));
		end
		idx_s1 <= idx_calc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kh_q <= '0;
			kw_q <= '0;
			vld_s1 <= 1'b0;
			range_q <= 1'b0;
		end else begin
			vld_s1 <= issue_en && inb;
			if (clr_acc) begin
				kh_q <= '0;
				kw_q <= '0;
				range_q <= rng;
			end else if (issue_en) begin
				if (kw_q == k_last) begin
					kw_q <= '0;
					kh_q <= kh_q + KW'(1);
				end else begin
					kw_q <= kw_q + KW'(1);
				end
			end
		end
	end

	// running sum and first greatest sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (clr_acc) begin
			seen_q <= 1'b0;
		end else if (vld_s1) begin
			seen_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_acc) begin
			sum_q <= '0;
		end else if (vld_s1) begin
			sum_q <= sum_q + SUM_W'(rd_data_s1);
			if (!seen_q || rd_data_s1 > best_q) begin
				best_q <= rd_data_s1;
				best_idx_q <= idx_s1;
			end
		end
	end

	// restoring divide of |sum| by K*K, one quotient bit per cycle
	assign rem_sh = {rem_q[RW-2:0], dvd_q[SUM_W-1]};
	assign div_ge = (rem_sh >= RW'(kk_q));
	assign avg_full = neg_q ? (~dvd_q + SUM_W'(1)) : dvd_q;

	always_ff @(posedge clk) begin
		if (state_q == FSM_DIV_LOAD) begin
			dvd_q <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
			neg_q <= sum_q[SUM_W-1];
			rem_q <= '0;
			kk_q <= kk;
			div_cnt_q <= DC_W'(SUM_W - 1);
		end else if (state_q == FSM_DIVIDE) begin
			rem_q <= div_ge ? (rem_sh - RW'(kk_q)) : rem_sh;
			dvd_q <= {dvd_q[SUM_W-2:0], div_ge};
			div_cnt_q <= div_cnt_q - DC_W'(1);
		end
	end

	always_comb begin
		if (range_q) begin
			res_status = STAT_RANGE;
			res_value = '0;
			res_idx = '0;
		end else if (!seen_q) begin
			res_status = STAT_EMPTY;
			res_value = '0;
			res_idx = '0;
		end else if (mode_q == MODE_AVG) begin
			res_status = STAT_OK;
			res_value = SAMPLE_BITS'(avg_full);
			res_idx = '0;
		end else begin
			res_status = STAT_OK;
			res_value = best_q;
			res_idx = best_idx_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q <= res_value;
			out_idx_q <= res_idx;
			out_status_q <= res_status;
		end
	end

	assign out_valid = out_valid_q;
	assign pooled_value = out_value_q;
	assign max_index = out_idx_q;
	assign status_code = out_status_q;

	// a sample only reaches the accumulator from a read issued during the walk
	a_vld_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> $past(state_q) == FSM_SCAN)
		else $error("accumulator fed outside window walk");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == STAT_RANGE) |-> (out_value_q == '0 && out_idx_q == '0))
		else $error("out-of-range result carries data");

	a_div_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_DIV_LOAD |-> (seen_q && mode_q == MODE_AVG))
		else $error("divide started without in-bounds samples");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_DIVIDE |-> rem_q < RW'(kk_q))
		else $error("divider remainder not below divisor");

endmodule
